// ===== rtl/core/line_sensor_centroid_macros.svh =====
// assertion macros shared by the line sensor rtl
`ifndef LINE_SENSOR_CENTROID_MACROS_SVH
`define LINE_SENSOR_CENTROID_MACROS_SVH
`ifndef SYNTH
`define LSC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`define LSC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define LSC_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`define LSC_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

// ===== rtl/core/lsc_pkg.sv =====
`default_nettype none
package lsc_pkg;

  localparam int SAMPLE_FIELD_W = 10;
  localparam int POS_W          = 13;
  localparam int THR_W          = 10;
  localparam int JMIN_W         = 4;
  localparam int DARK_W         = 4;
  localparam int WEIGHT_W       = 10;
  localparam int REQ_W          = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 13;
  localparam int FULL_SCALE     = 1000;

  localparam logic [REQ_W-1:0] REQ_MEASURE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CAL     = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MID_POS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE_THR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JUNCTION  = 2'd2;

  localparam logic [POS_W-1:0]  MID_POS_RST   = 13'd3500;
  localparam logic [THR_W-1:0]  NOISE_THR_RST = 10'd200;
  localparam logic [JMIN_W-1:0] JUNCTION_RST  = 4'd5;

  typedef enum logic [1:0] {
    CAL_NOP,
    CAL_WIDEN,
    CAL_CLEAR
  } cal_op_t;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic [SAMPLE_FIELD_W-1:0] sample_0;
    logic [SAMPLE_FIELD_W-1:0] sample_1;
    logic [SAMPLE_FIELD_W-1:0] sample_2;
    logic [SAMPLE_FIELD_W-1:0] sample_3;
    logic [SAMPLE_FIELD_W-1:0] sample_4;
    logic [SAMPLE_FIELD_W-1:0] sample_5;
    logic [SAMPLE_FIELD_W-1:0] sample_6;
    logic [SAMPLE_FIELD_W-1:0] sample_7;
    logic [POS_W-1:0]          last_position;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic              line_lost;
    logic              junction;
    logic [DARK_W-1:0] dark_count;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/line_sensor_centroid.sv =====
`default_nettype none
`include "line_sensor_centroid_macros.svh"
// Line sensor centroid: takes one item at a time (in_stall is high while an item
// is in work). A calibrate or clear item gives no result. Each channel of a
// measure item and, unless the line is lost, the final centroid go through one
// shared 13-step restoring divider. A finished result sits in the output
// register, so the next item is taken while it waits; calibration state and the
// config registers come up at their reset values, with no sweep.
module line_sensor_centroid #(
  parameter int NUM_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire lsc_pkg::in_item_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output lsc_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_wr_en,
  input  wire logic [lsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SB        = SAMPLE_BITS;
  localparam int CH_W      = $clog2(NUM_CHANNELS);
  localparam int POS_W     = lsc_pkg::POS_W;
  localparam int WEIGHT_W  = lsc_pkg::WEIGHT_W;
  localparam int NUMER_W   = SB + WEIGHT_W;
  localparam int SUM_W     = $clog2(lsc_pkg::FULL_SCALE * NUM_CHANNELS + 1);
  localparam int WSUM_W    = $clog2(lsc_pkg::FULL_SCALE * lsc_pkg::FULL_SCALE *
                                    NUM_CHANNELS * (NUM_CHANNELS - 1) / 2 + 1);
  localparam int DIV_NUM_W = (NUMER_W > WSUM_W) ? NUMER_W : WSUM_W;
  localparam int DIV_DEN_W = (SB > SUM_W) ? SB : SUM_W;
  localparam int PROD_W    = WEIGHT_W + POS_W;
  localparam int DARK_W    = lsc_pkg::DARK_W;
  localparam logic [POS_W-1:0] POS_MAX =
    POS_W'((NUM_CHANNELS - 1) * lsc_pkg::FULL_SCALE);
  localparam logic [WEIGHT_W-1:0] FULL_W = WEIGHT_W'(lsc_pkg::FULL_SCALE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_CHAN,
    S_DIV,
    S_POS,
    S_PDIV,
    S_DONE
  } state_t;

  state_t                       state_r, state_nxt;
  lsc_pkg::in_item_t            item_r, item_nxt;
  logic [CH_W-1:0]              ch_r, ch_nxt;
  logic [POS_W-1:0]             cpos_r, cpos_nxt;
  logic [DARK_W-1:0]            dark_r, dark_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [WSUM_W-1:0]            wsum_r, wsum_nxt;
  logic [POS_W-1:0]             pos_r, pos_nxt;
  logic                         lost_r, lost_nxt;
  logic                         out_valid_r, out_valid_nxt;
  lsc_pkg::out_item_t           out_data_r, out_data_nxt;
  logic [POS_W-1:0]             center_r, center_nxt;
  logic [lsc_pkg::THR_W-1:0]    thr_r, thr_nxt;
  logic [lsc_pkg::JMIN_W-1:0]   jmin_r, jmin_nxt;

  logic [lsc_pkg::SAMPLE_FIELD_W-1:0]      fld [8];
  logic [NUM_CHANNELS-1:0][SB-1:0]         samp;
  logic [SB-1:0]                           samp_sel;
  logic [SB-1:0]                           rd_lo, rd_hi;
  logic [SB:0]                             hi_eff, v_lo, v_cl, diff, den_full;
  logic [NUMER_W-1:0]                      numer;
  lsc_pkg::cal_op_t                        cal_op;
  logic                                    div_start, div_done;
  logic [DIV_NUM_W-1:0]                    div_num;
  logic [DIV_DEN_W-1:0]                    div_den;
  logic [POS_W-1:0]                        div_quo;
  logic [WEIGHT_W-1:0]                     weight;
  logic [PROD_W-1:0]                       prod;
  logic                                    is_dark;
  logic                                    in_acc;

  always_comb begin
    fld[0] = item_r.sample_0;
    fld[1] = item_r.sample_1;
    fld[2] = item_r.sample_2;
    fld[3] = item_r.sample_3;
    fld[4] = item_r.sample_4;
    fld[5] = item_r.sample_5;
    fld[6] = item_r.sample_6;
    fld[7] = item_r.sample_7;
  end

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_samp
    logic [lsc_pkg::SAMPLE_FIELD_W+SB-1:0] ext;
    assign ext     = {{SB{1'b0}}, fld[c]};
    assign samp[c] = ext[SB-1:0];
  end

  lsc_cal_store #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_cal (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (cal_op),
    .samples (samp),
    .rd_idx  (ch_r),
    .rd_lo   (rd_lo),
    .rd_hi   (rd_hi)
  );

  lsc_divider #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .QUO_W (POS_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // clamp into the calibrated range, empty range widened by one
  assign samp_sel = samp[ch_r];
  assign hi_eff   = (rd_hi <= rd_lo) ? ({1'b0, rd_lo} + (SB+1)'(1)) : {1'b0, rd_hi};
  assign v_lo     = (samp_sel < rd_lo) ? {1'b0, rd_lo} : {1'b0, samp_sel};
  assign v_cl     = (v_lo > hi_eff) ? hi_eff : v_lo;
  assign diff     = v_cl - {1'b0, rd_lo};
  assign den_full = hi_eff - {1'b0, rd_lo};
  assign numer    = NUMER_W'(diff[SB-1:0]) * NUMER_W'(lsc_pkg::FULL_SCALE);

  assign weight  = FULL_W - div_quo[WEIGHT_W-1:0];
  assign is_dark = (weight > thr_r);
  assign prod    = PROD_W'(weight) * PROD_W'(cpos_r);

  assign div_start = (state_r == S_CHAN) || ((state_r == S_POS) && (dark_r != '0));
  assign div_num   = (state_r == S_CHAN) ? DIV_NUM_W'(numer) : DIV_NUM_W'(wsum_r);
  assign div_den   = (state_r == S_CHAN) ? DIV_DEN_W'(den_full[SB-1:0]) : DIV_DEN_W'(sum_r);

  always_comb begin
    cal_op = lsc_pkg::CAL_NOP;
    if (state_r == S_APPLY) begin
      case (item_r.req_type)
        lsc_pkg::REQ_CAL:   cal_op = lsc_pkg::CAL_WIDEN;
        lsc_pkg::REQ_CLEAR: cal_op = lsc_pkg::CAL_CLEAR;
        default:            cal_op = lsc_pkg::CAL_NOP;
      endcase
    end
  end

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    ch_nxt        = ch_r;
    cpos_nxt      = cpos_r;
    dark_nxt      = dark_r;
    sum_nxt       = sum_r;
    wsum_nxt      = wsum_r;
    pos_nxt       = pos_r;
    lost_nxt      = lost_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    center_nxt    = center_r;
    thr_nxt       = thr_r;
    jmin_nxt      = jmin_r;

    if (cfg_wr_en) begin
      case (cfg_index)
        lsc_pkg::CFG_MID_POS:   center_nxt = cfg_wdata;
        lsc_pkg::CFG_NOISE_THR: thr_nxt    = cfg_wdata[lsc_pkg::THR_W-1:0];
        lsc_pkg::CFG_JUNCTION:  jmin_nxt   = cfg_wdata[lsc_pkg::JMIN_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          item_nxt = in_data;
          ch_nxt   = '0;
          cpos_nxt = '0;
          dark_nxt = '0;
          sum_nxt  = '0;
          wsum_nxt = '0;
          case (in_data.req_type)
            lsc_pkg::REQ_MEASURE: state_nxt = S_CHAN;
            lsc_pkg::REQ_CAL:     state_nxt = S_APPLY;
            lsc_pkg::REQ_CLEAR:   state_nxt = S_APPLY;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_APPLY: state_nxt = S_IDLE;
      S_CHAN:  state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) begin
          if (is_dark) begin
            dark_nxt = dark_r + DARK_W'(1);
            sum_nxt  = sum_r + SUM_W'(weight);
            wsum_nxt = wsum_r + WSUM_W'(prod);
          end
          cpos_nxt = cpos_r + POS_W'(lsc_pkg::FULL_SCALE);
          if (ch_r == CH_W'(NUM_CHANNELS - 1)) begin
            state_nxt = S_POS;
          end else begin
            ch_nxt    = ch_r + CH_W'(1);
            state_nxt = S_CHAN;
          end
        end
      end
      S_POS: begin
        if (dark_r == '0) begin
          lost_nxt  = 1'b1;
          pos_nxt   = (item_r.last_position < center_r) ? '0 : POS_MAX;
          state_nxt = S_DONE;
        end else begin
          lost_nxt  = 1'b0;
          state_nxt = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_done) begin
          pos_nxt   = div_quo;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.position   = pos_r;
          out_data_nxt.line_lost  = lost_r;
          out_data_nxt.junction   = (dark_r >= jmin_r);
          out_data_nxt.dark_count = dark_r;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lost_r      <= 1'b0;
      center_r    <= lsc_pkg::MID_POS_RST;
      thr_r       <= lsc_pkg::NOISE_THR_RST;
      jmin_r      <= lsc_pkg::JUNCTION_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      lost_r      <= lost_nxt;
      center_r    <= center_nxt;
      thr_r       <= thr_nxt;
      jmin_r      <= jmin_nxt;
    end
    item_r     <= item_nxt;
    ch_r       <= ch_nxt;
    cpos_r     <= cpos_nxt;
    dark_r     <= dark_nxt;
    sum_r      <= sum_nxt;
    wsum_r     <= wsum_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LSC_ASSERT_IMP(a_dark_bound, clk, rst_n, out_valid_r, out_data_r.dark_count <= DARK_W'(NUM_CHANNELS))
  `LSC_ASSERT_IMP(a_lost_iff_none, clk, rst_n, out_valid_r, out_data_r.line_lost == (out_data_r.dark_count == '0))
  `LSC_ASSERT_IMP(a_pos_bound, clk, rst_n, out_valid_r, out_data_r.position <= POS_MAX)

endmodule
`default_nettype wire

// ===== rtl/core/lsc_divider.sv =====
`default_nettype none
`include "line_sensor_centroid_macros.svh"
module lsc_divider #(
  parameter int NUM_W = 25,
  parameter int DEN_W = 13,
  parameter int QUO_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [QUO_W-1:0]      quo
);

  localparam int SH_W  = DEN_W + QUO_W - 1;
  localparam int CW    = (NUM_W > SH_W) ? NUM_W : SH_W;
  localparam int CNT_W = $clog2(QUO_W);

  logic [NUM_W-1:0] rem_r, rem_nxt;
  logic [SH_W-1:0]  dsh_r, dsh_nxt;
  logic [QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW:0]      trial;
  logic             ge;

  assign trial = {1'b0, CW'(rem_r)} - {1'b0, CW'(dsh_r)};
  assign ge    = ~trial[CW];

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num;
      dsh_nxt  = {den, {(QUO_W-1){1'b0}}};
      cnt_nxt  = CNT_W'(QUO_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // one restoring step per cycle
      rem_nxt  = ge ? trial[NUM_W-1:0] : rem_r;
      quo_nxt  = {quo_r[QUO_W-2:0], ge};
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != '0);
      done_nxt = (cnt_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

  `LSC_ASSERT_IMP(a_div_no_restart, clk, rst_n, start, !busy_r)
  `LSC_ASSERT_NXT(a_div_finish, clk, rst_n, busy_r && (cnt_r == '0), done_r && !busy_r)

endmodule
`default_nettype wire

// ===== rtl/core/lsc_cal_store.sv =====
`default_nettype none
module lsc_cal_store #(
  parameter int NUM_CHANNELS = 8,
  parameter int SAMPLE_BITS  = 10
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire lsc_pkg::cal_op_t                        op,
  input  wire logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] samples,
  input  wire logic [$clog2(NUM_CHANNELS)-1:0]         rd_idx,
  output logic [SAMPLE_BITS-1:0]                       rd_lo,
  output logic [SAMPLE_BITS-1:0]                       rd_hi
);

  logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] lo_r, lo_nxt;
  logic [NUM_CHANNELS-1:0][SAMPLE_BITS-1:0] hi_r, hi_nxt;

  always_comb begin
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    case (op)
      lsc_pkg::CAL_WIDEN: begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          if (samples[c] < lo_r[c]) lo_nxt[c] = samples[c];
          if (samples[c] > hi_r[c]) hi_nxt[c] = samples[c];
        end
      end
      lsc_pkg::CAL_CLEAR: begin
        lo_nxt = '1;
        hi_nxt = '0;
      end
      default: begin
        lo_nxt = lo_r;
        hi_nxt = hi_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r <= '1;
      hi_r <= '0;
    end else begin
      lo_r <= lo_nxt;
      hi_r <= hi_nxt;
    end
  end

  assign rd_lo = lo_r[rd_idx];
  assign rd_hi = hi_r[rd_idx];

endmodule
`default_nettype wire

// ===== sim/tb_line_sensor_centroid.sv =====
`default_nettype none
module tb_line_sensor_centroid;

  localparam logic [lsc_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CHANNELS = 8;
  localparam int SAMPLE_MAX = 1023;
  localparam int POS_MAX = (CHANNELS - 1) * lsc_pkg::FULL_SCALE;
  localparam int PHASE_ITEMS = 445;
  localparam int QUIET_LIMIT = 5000;

  class centroid_scoreboard;
    int unsigned cal_lo[CHANNELS];
    int unsigned cal_hi[CHANNELS];
    int unsigned mid_pos;
    int unsigned noise_thr;
    int unsigned junction_min;
    lsc_pkg::out_item_t pos_q[$];
    int errors;
    int printed;
    int results;
    int lost_seen;
    int junction_seen;

    function new();
      clear_cal();
      mid_pos = lsc_pkg::MID_POS_RST;
      noise_thr = lsc_pkg::NOISE_THR_RST;
      junction_min = lsc_pkg::JUNCTION_RST;
    endfunction

    function void clear_cal();
      for (int c = 0; c < CHANNELS; c++) begin
        cal_lo[c] = SAMPLE_MAX;
        cal_hi[c] = 0;
      end
    endfunction

    function void set_regs(int unsigned center, int unsigned thr, int unsigned jmin);
      mid_pos = center & 32'h1FFF;
      noise_thr = thr & 32'h3FF;
      junction_min = jmin & 32'hF;
    endfunction

    function void note_input(lsc_pkg::in_item_t it);
      int unsigned smp[CHANNELS];
      int unsigned lo, hi, v, w, dark, wsum, wtot, pos;
      lsc_pkg::out_item_t res;
      smp = '{it.sample_0, it.sample_1, it.sample_2, it.sample_3,
              it.sample_4, it.sample_5, it.sample_6, it.sample_7};
      case (it.req_type)
        lsc_pkg::REQ_CLEAR: clear_cal();
        lsc_pkg::REQ_CAL: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (smp[c] < cal_lo[c]) cal_lo[c] = smp[c];
            if (smp[c] > cal_hi[c]) cal_hi[c] = smp[c];
          end
        end
        lsc_pkg::REQ_MEASURE: begin
          dark = 0;
          wsum = 0;
          wtot = 0;
          for (int c = 0; c < CHANNELS; c++) begin
            lo = cal_lo[c];
            hi = (cal_hi[c] <= lo) ? lo + 1 : cal_hi[c];
            v = (smp[c] < lo) ? lo : ((smp[c] > hi) ? hi : smp[c]);
            w = lsc_pkg::FULL_SCALE - ((v - lo) * lsc_pkg::FULL_SCALE) / (hi - lo);
            if (w > noise_thr) dark++;
            else w = 0;
            wsum += w * c * lsc_pkg::FULL_SCALE;
            wtot += w;
          end
          res.dark_count = dark[lsc_pkg::DARK_W-1:0];
          res.junction = (dark >= junction_min);
          res.line_lost = (dark == 0 || wtot == 0);
          if (res.line_lost) pos = (it.last_position < mid_pos) ? 0 : POS_MAX;
          else pos = wsum / wtot;
          res.position = pos[lsc_pkg::POS_W-1:0];
          pos_q.push_back(res);
        end
        default: ;
      endcase
    endfunction

    task report(string what, int got, int want);
      errors++;
      if (printed < 40) begin
        printed++;
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      end
    endtask

    task check_result(lsc_pkg::out_item_t r);
      lsc_pkg::out_item_t e;
      results++;
      if (r.line_lost === 1'b1) lost_seen++;
      if (r.junction === 1'b1) junction_seen++;
      if (pos_q.size() == 0) begin
        report("unexpected result transaction", r.position, -1);
        return;
      end
      e = pos_q.pop_front();
      if (r.position !== e.position) report("position", r.position, e.position);
      if (r.line_lost !== e.line_lost) report("line_lost", r.line_lost, e.line_lost);
      if (r.junction !== e.junction) report("junction", r.junction, e.junction);
      if (r.dark_count !== e.dark_count) report("dark_count", r.dark_count, e.dark_count);
    endtask
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  lsc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lsc_pkg::out_item_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [lsc_pkg::CFG_IDX_W-1:0] cfg_index = lsc_pkg::CFG_MID_POS;
  logic [lsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  centroid_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int n_measure = 0;
  int n_cal = 0;
  int n_clear = 0;
  int n_unused = 0;
  int unsigned tgt_lo[CHANNELS];
  int unsigned tgt_hi[CHANNELS];

  line_sensor_centroid u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) sb.check_result(out_data);
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", quiet_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic lsc_pkg::in_item_t pack_item(logic [lsc_pkg::REQ_W-1:0] req,
                                                  int unsigned smp[CHANNELS],
                                                  int unsigned last_pos);
    lsc_pkg::in_item_t it;
    it.req_type = req;
    it.sample_0 = smp[0][lsc_pkg::SAMPLE_FIELD_W-1:0];
    it.sample_1 = smp[1][lsc_pkg::SAMPLE_FIELD_W-1:0];
    it.sample_2 = smp[2][lsc_pkg::SAMPLE_FIELD_W-1:0];
    it.sample_3 = smp[3][lsc_pkg::SAMPLE_FIELD_W-1:0];
    it.sample_4 = smp[4][lsc_pkg::SAMPLE_FIELD_W-1:0];
    it.sample_5 = smp[5][lsc_pkg::SAMPLE_FIELD_W-1:0];
    it.sample_6 = smp[6][lsc_pkg::SAMPLE_FIELD_W-1:0];
    it.sample_7 = smp[7][lsc_pkg::SAMPLE_FIELD_W-1:0];
    it.last_position = last_pos[lsc_pkg::POS_W-1:0];
    return it;
  endfunction

  function automatic lsc_pkg::in_item_t flat_item(logic [lsc_pkg::REQ_W-1:0] req,
                                                  int unsigned val, int unsigned last_pos);
    int unsigned smp[CHANNELS];
    foreach (smp[c]) smp[c] = val;
    return pack_item(req, smp, last_pos);
  endfunction

  // dark channels read low, light channels read near the calibrated maximum
  function automatic lsc_pkg::in_item_t line_item();
    int unsigned smp[CHANNELS];
    int unsigned mode, centre, spread, d, f, span;
    int level;
    mode = $urandom_range(0, 9);
    centre = $urandom_range(0, POS_MAX);
    spread = (mode == 1) ? $urandom_range(2000, 5000) : $urandom_range(300, 1500);
    for (int c = 0; c < CHANNELS; c++) begin
      d = (c * lsc_pkg::FULL_SCALE > centre) ? c * lsc_pkg::FULL_SCALE - centre
                                             : centre - c * lsc_pkg::FULL_SCALE;
      f = (mode == 0 || d >= spread) ? 0
                                     : lsc_pkg::FULL_SCALE - d * lsc_pkg::FULL_SCALE / spread;
      span = tgt_hi[c] - tgt_lo[c];
      level = int'(tgt_hi[c] - span * f / lsc_pkg::FULL_SCALE) +
              int'($urandom_range(0, 60)) - 30;
      if (mode == 2) level = $urandom_range(0, SAMPLE_MAX);
      smp[c] = (level < 0) ? 0 : ((level > SAMPLE_MAX) ? SAMPLE_MAX : level);
    end
    return pack_item(lsc_pkg::REQ_MEASURE, smp, $urandom_range(0, POS_MAX));
  endfunction

  task automatic send_item(input lsc_pkg::in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_input(it);
    case (it.req_type)
      lsc_pkg::REQ_MEASURE: n_measure++;
      lsc_pkg::REQ_CAL: n_cal++;
      lsc_pkg::REQ_CLEAR: n_clear++;
      default: n_unused++;
    endcase
  endtask

  task automatic drain(int settle);
    in_valid <= 1'b0;
    while (sb.pos_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_config(int unsigned center, int unsigned thr, int unsigned jmin);
    drain(16);
    cfg_wr_en <= 1'b1;
    cfg_index <= lsc_pkg::CFG_MID_POS;
    cfg_wdata <= center[lsc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= lsc_pkg::CFG_NOISE_THR;
    cfg_wdata <= thr[lsc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_index <= lsc_pkg::CFG_JUNCTION;
    cfg_wdata <= jmin[lsc_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_regs(center, thr, jmin);
  endtask

  // clear, then widen with the low targets, the high targets and some in between
  task automatic calibrate_run();
    int unsigned smp[CHANNELS];
    int extra;
    foreach (tgt_lo[c]) begin
      tgt_lo[c] = $urandom_range(0, 400);
      tgt_hi[c] = ($urandom_range(0, 19) == 0) ? tgt_lo[c]
                                                 : $urandom_range(tgt_lo[c], SAMPLE_MAX);
    end
    send_item(flat_item(lsc_pkg::REQ_CLEAR, $urandom_range(0, SAMPLE_MAX),
                        $urandom_range(0, POS_MAX)));
    send_item(pack_item(lsc_pkg::REQ_CAL, tgt_lo, $urandom_range(0, POS_MAX)));
    send_item(pack_item(lsc_pkg::REQ_CAL, tgt_hi, $urandom_range(0, POS_MAX)));
    extra = $urandom_range(0, 2);
    repeat (extra) begin
      foreach (smp[c]) smp[c] = $urandom_range(tgt_lo[c], tgt_hi[c]);
      send_item(pack_item(lsc_pkg::REQ_CAL, smp, $urandom_range(0, POS_MAX)));
    end
  endtask

  task automatic noise_item();
    int unsigned smp[CHANNELS];
    foreach (smp[c]) smp[c] = $urandom_range(0, SAMPLE_MAX);
    send_item(pack_item(lsc_pkg::REQ_W'($urandom_range(0, 3)), smp,
                        $urandom_range(0, POS_MAX)));
  endtask

  initial begin
    int unsigned smp[CHANNELS];
    int start_count;
    foreach (tgt_lo[c]) begin
      tgt_lo[c] = 0;
      tgt_hi[c] = SAMPLE_MAX;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // uncalibrated channels, the unused request code, full-range calibration
    send_item(flat_item(lsc_pkg::REQ_MEASURE, 0, 100));
    send_item(flat_item(REQ_UNUSED, SAMPLE_MAX, POS_MAX));
    send_item(flat_item(lsc_pkg::REQ_CAL, 0, 0));
    send_item(flat_item(lsc_pkg::REQ_CAL, SAMPLE_MAX, POS_MAX));
    send_item(flat_item(lsc_pkg::REQ_MEASURE, 0, 0));
    send_item(flat_item(lsc_pkg::REQ_MEASURE, SAMPLE_MAX, 0));
    send_item(flat_item(lsc_pkg::REQ_MEASURE, SAMPLE_MAX, lsc_pkg::MID_POS_RST));
    foreach (smp[c]) smp[c] = (c == 0) ? 0 : SAMPLE_MAX;
    send_item(pack_item(lsc_pkg::REQ_MEASURE, smp, 2000));
    foreach (smp[c]) smp[c] = (c == CHANNELS - 1) ? 0 : SAMPLE_MAX;
    send_item(pack_item(lsc_pkg::REQ_MEASURE, smp, POS_MAX));
    foreach (smp[c]) smp[c] = (c % 2) ? 10'h2AA : 10'h155;
    send_item(pack_item(lsc_pkg::REQ_MEASURE, smp, 13'h0AAA));
    // clear keeps the flags, measure on an empty calibration
    send_item(flat_item(lsc_pkg::REQ_CLEAR, 10'h2AA, 13'h1555));
    send_item(flat_item(lsc_pkg::REQ_MEASURE, 512, POS_MAX));
    send_item(flat_item(lsc_pkg::REQ_CAL, 10'h155, 1));
    send_item(flat_item(lsc_pkg::REQ_CAL, 10'h2AA, 2));
    foreach (smp[c]) smp[c] = (c < 4) ? 0 : SAMPLE_MAX;
    send_item(pack_item(lsc_pkg::REQ_MEASURE, smp, 3499));

    // threshold at full scale, junction always flagged, lowest center
    set_config(0, lsc_pkg::FULL_SCALE, 0);
    send_item(flat_item(lsc_pkg::REQ_MEASURE, 0, 0));
    send_item(flat_item(lsc_pkg::REQ_MEASURE, SAMPLE_MAX, POS_MAX));
    // zero threshold, junction needs all channels, highest center
    set_config(POS_MAX, 0, CHANNELS);
    send_item(flat_item(lsc_pkg::REQ_MEASURE, 0, 0));
    send_item(flat_item(lsc_pkg::REQ_MEASURE, SAMPLE_MAX, POS_MAX - 1));
    send_item(flat_item(lsc_pkg::REQ_MEASURE, SAMPLE_MAX, POS_MAX));
    foreach (smp[c]) smp[c] = (c == 3) ? 500 : SAMPLE_MAX;
    send_item(pack_item(lsc_pkg::REQ_MEASURE, smp, 0));

    for (int phase = 0; phase < 4; phase++) begin
      if (phase == 0) begin
        set_config(lsc_pkg::MID_POS_RST, lsc_pkg::NOISE_THR_RST, lsc_pkg::JUNCTION_RST);
      end else begin
        set_config($urandom_range(0, POS_MAX), $urandom_range(0, 600), $urandom_range(0, 8));
      end
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      calibrate_run();
      start_count = n_measure + n_cal + n_clear;
      while (n_measure + n_cal + n_clear - start_count < PHASE_ITEMS) begin
        case ($urandom_range(0, 24))
          0, 1: calibrate_run();
          2, 3: noise_item();
          default: send_item(line_item());
        endcase
      end
    end

    drain(150);
    $display("covered %0d measure, %0d calibrate, %0d clear, %0d unused-code transactions",
             n_measure, n_cal, n_clear, n_unused);
    $display("checked %0d results: %0d with line lost, %0d with junction, %0d errors",
             sb.results, sb.lost_seen, sb.junction_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== line_sensor_centroid.f =====
+incdir+rtl/core
rtl/core/lsc_pkg.sv
rtl/core/lsc_divider.sv
rtl/core/lsc_cal_store.sv
rtl/core/line_sensor_centroid.sv
sim/tb_line_sensor_centroid.sv
